### hw/rtl/cmig_pkg.sv
// Package for the capsule mesh index generator.
// Holds the shared types, register indexes and mesh constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmig_pkg;

    // Mesh size limits
    localparam int MIN_SEGMENTS = 3;
    localparam int MAX_SEGMENTS = 64;

    // Field widths
    localparam int SEG_W   = 7;   // segment count register
    localparam int CNT_W   = 6;   // ring and slice counters
    localparam int SQ_W    = 13;  // segment count squared
    localparam int IDX_W   = 14;  // one vertex index
    localparam int VCNT_W  = 3;   // number of meaningful indices
    localparam int NUM_IDX = 6;

    // Configuration register indexes
    localparam logic REG_SEGMENT_COUNT = 1'b0;
    localparam logic REG_LIST_MODE     = 1'b1;

    // Index counts per cell
    localparam logic [VCNT_W-1:0] VCNT_FULL = 3'd6;
    localparam logic [VCNT_W-1:0] VCNT_RIM  = 3'd4;

    // Part of the mesh a cell belongs to
    typedef enum logic [1:0] {
        PART_TOP    = 2'd0,
        PART_BOTTOM = 2'd1,
        PART_CYL    = 2'd2
    } part_t;

    // Coordinates of one cell, registered after the counters
    typedef struct packed {
        part_t             part;
        logic [CNT_W-1:0]  ring;
        logic [CNT_W-1:0]  slice;
        logic [CNT_W-1:0]  slice_nxt;  // slice + 1, wrapped to zero
        logic [SEG_W-1:0]  seg;
        logic [SQ_W-1:0]   seg_sq;
        logic              line_mode;
        logic              last;
    } cell_t;

    // Indices of one cell
    typedef struct packed {
        logic [NUM_IDX-1:0][IDX_W-1:0] idx;  // idx[0] is index_a
        logic [VCNT_W-1:0]             valid_count;
        part_t                         part;
        logic                          last;
    } cell_idx_t;

endpackage

`default_nettype wire

### hw/rtl/cmig_cell_seq.sv
// Cell sequencer: configuration registers, ring/slice/section counters and
// the cell register. Depends on cmig_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmig_cell_seq (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration write port
    input  wire logic                       cfg_wen,
    input  wire logic                       cfg_addr,
    input  wire logic [cmig_pkg::SEG_W-1:0] cfg_wdata,
    // item request
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire logic                       restart,
    // registered cell towards the index stage
    output logic                            cell_valid,
    input  wire logic                       cell_ready,
    output cmig_pkg::cell_t                 cell_out
);

    logic [cmig_pkg::SEG_W-1:0] seg_reg, seg_next;
    logic [cmig_pkg::SQ_W-1:0]  seg_sq_reg, seg_sq_next;
    logic                       mode_reg, mode_next;

    cmig_pkg::part_t            part_reg, part_next;
    logic [cmig_pkg::CNT_W-1:0] ring_reg, ring_next;
    logic [cmig_pkg::CNT_W-1:0] slice_reg, slice_next;

    logic                       cell_vld_reg, cell_vld_next;
    cmig_pkg::cell_t            cell_reg, cell_next;

    cmig_pkg::part_t            cur_part;
    logic [cmig_pkg::CNT_W-1:0] cur_ring;
    logic [cmig_pkg::CNT_W-1:0] cur_slice;
    logic [cmig_pkg::SEG_W-1:0] slice_inc;
    logic                       slice_wrap;
    logic                       ring_wrap;
    logic                       seg_legal;
    logic                       accept;

    assign req_ready = !cell_vld_reg || cell_ready;
    assign accept    = req_valid && req_ready;

    assign seg_legal = (cfg_wdata >= cmig_pkg::SEG_W'(cmig_pkg::MIN_SEGMENTS)) &&
                       (cfg_wdata <= cmig_pkg::SEG_W'(cmig_pkg::MAX_SEGMENTS));

    // Current cell: a restart rewinds before the cell is used
    always_comb begin
        cur_part   = restart ? cmig_pkg::PART_TOP : part_reg;
        cur_ring   = restart ? '0 : ring_reg;
        cur_slice  = restart ? '0 : slice_reg;
        slice_inc  = {1'b0, cur_slice} + cmig_pkg::SEG_W'(1);
        slice_wrap = (slice_inc >= seg_reg);
        ring_wrap  = (({1'b0, cur_ring} + cmig_pkg::SEG_W'(2)) >= seg_reg);
    end

    // Counter advance, then configuration writes, which take priority over it
    always_comb begin
        seg_next    = seg_reg;
        seg_sq_next = seg_sq_reg;
        mode_next   = mode_reg;
        part_next   = part_reg;
        ring_next   = ring_reg;
        slice_next  = slice_reg;

        if (accept) begin
            if (cur_part == cmig_pkg::PART_CYL) begin
                if (slice_wrap) begin
                    part_next  = cmig_pkg::PART_TOP;
                    ring_next  = '0;
                    slice_next = '0;
                end else begin
                    part_next  = cur_part;
                    ring_next  = cur_ring;
                    slice_next = slice_inc[cmig_pkg::CNT_W-1:0];
                end
            end else begin
                part_next  = cur_part;
                ring_next  = cur_ring + cmig_pkg::CNT_W'(1);
                slice_next = cur_slice;
                if (ring_wrap) begin
                    ring_next = '0;
                    if (slice_wrap) begin
                        slice_next = '0;
                        part_next  = (cur_part == cmig_pkg::PART_TOP) ?
                                     cmig_pkg::PART_BOTTOM : cmig_pkg::PART_CYL;
                    end else begin
                        slice_next = slice_inc[cmig_pkg::CNT_W-1:0];
                    end
                end
            end
        end

        if (cfg_wen) begin
            unique case (cfg_addr)
                cmig_pkg::REG_SEGMENT_COUNT: begin
                    if (seg_legal) begin
                        seg_next    = cfg_wdata;
                        seg_sq_next = cmig_pkg::SQ_W'(
                            cmig_pkg::IDX_W'(cfg_wdata) * cmig_pkg::IDX_W'(cfg_wdata));
                        part_next   = cmig_pkg::PART_TOP;
                        ring_next   = '0;
                        slice_next  = '0;
                    end
                end
                cmig_pkg::REG_LIST_MODE: begin
                    mode_next = cfg_wdata[0];
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Cell register
    always_comb begin
        cell_vld_next = cell_vld_reg;
        cell_next     = cell_reg;
        if (cell_ready) begin
            cell_vld_next = 1'b0;
        end
        if (accept) begin
            cell_vld_next       = 1'b1;
            cell_next.part      = cur_part;
            cell_next.ring      = cur_ring;
            cell_next.slice     = cur_slice;
            cell_next.slice_nxt = slice_wrap ? '0 : slice_inc[cmig_pkg::CNT_W-1:0];
            cell_next.seg       = seg_reg;
            cell_next.seg_sq    = seg_sq_reg;
            cell_next.line_mode = mode_reg;
            cell_next.last      = (cur_part == cmig_pkg::PART_CYL) && slice_wrap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg      <= cmig_pkg::SEG_W'(cmig_pkg::MIN_SEGMENTS);
            seg_sq_reg   <= cmig_pkg::SQ_W'(cmig_pkg::MIN_SEGMENTS * cmig_pkg::MIN_SEGMENTS);
            mode_reg     <= 1'b0;
            part_reg     <= cmig_pkg::PART_TOP;
            ring_reg     <= '0;
            slice_reg    <= '0;
            cell_vld_reg <= 1'b0;
        end else begin
            seg_reg      <= seg_next;
            seg_sq_reg   <= seg_sq_next;
            mode_reg     <= mode_next;
            part_reg     <= part_next;
            ring_reg     <= ring_next;
            slice_reg    <= slice_next;
            cell_vld_reg <= cell_vld_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
    end

    assign cell_valid = cell_vld_reg;
    assign cell_out   = cell_reg;

    // Counters stay inside the grid of the current segment count
    a_ring_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, ring_reg} + cmig_pkg::SEG_W'(2)) <= seg_reg)
        else $error("ring counter beyond last row");

    a_slice_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, slice_reg} < seg_reg)
        else $error("slice counter beyond last column");

    // A legal segment count write rewinds the generator
    a_seg_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wen && (cfg_addr == cmig_pkg::REG_SEGMENT_COUNT) && seg_legal) |=>
        ((part_reg == cmig_pkg::PART_TOP) && (ring_reg == '0) && (slice_reg == '0)))
        else $error("segment count write did not rewind");

endmodule

`default_nettype wire

### hw/rtl/cmig_index_calc.sv
// Index calculation for one registered cell: hemisphere and cylinder
// vertex indices in triangle or line order. Depends on cmig_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmig_index_calc (
    input  cmig_pkg::cell_t     cell_in,
    output cmig_pkg::cell_idx_t res
);

    localparam int W = cmig_pkg::IDX_W;

    logic [W-1:0] off;
    logic [W-1:0] p, q, p1, q1;
    logic [W-1:0] t, u, t1, u1;

    // Grid positions
    always_comb begin
        off = (cell_in.part == cmig_pkg::PART_BOTTOM) ? W'(cell_in.seg_sq) : '0;
        p   = off + W'(cell_in.slice) * W'(cell_in.seg) + W'(cell_in.ring);
        q   = off + W'(cell_in.slice_nxt) * W'(cell_in.seg) + W'(cell_in.ring);
        p1  = p + W'(1);
        q1  = q + W'(1);
        t   = W'({cell_in.seg_sq, 1'b0}) + W'({cell_in.slice, 1'b0});
        u   = W'({cell_in.seg_sq, 1'b0}) + W'({cell_in.slice_nxt, 1'b0});
        t1  = t + W'(1);
        u1  = u + W'(1);
    end

    // Winding per part and mode
    always_comb begin
        res.valid_count = cmig_pkg::VCNT_FULL;
        res.part        = cell_in.part;
        res.last        = cell_in.last;
        res.idx         = '0;
        unique case (cell_in.part)
            cmig_pkg::PART_TOP: begin
                if (cell_in.line_mode) begin
                    res.idx = {q1, p, q, p, p1, p};
                end else begin
                    res.idx = {q, q1, p, q1, p1, p};
                end
            end
            cmig_pkg::PART_BOTTOM: begin
                if (cell_in.line_mode) begin
                    res.idx = {p1, p, p, q, q1, p};
                end else begin
                    res.idx = {q1, q, p, p1, q1, p};
                end
            end
            cmig_pkg::PART_CYL: begin
                if (cell_in.line_mode) begin
                    res.idx         = {W'(0), W'(0), t, t1, u1, t};
                    res.valid_count = cmig_pkg::VCNT_RIM;
                end else begin
                    res.idx = {u1, u, t, t1, u1, t};
                end
            end
            default: begin
                res.idx = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/capsule_mesh_index_generator.sv
// Top level of the capsule mesh index generator: stream ports, cell
// sequencer, index calculation and output register. Depends on cmig_pkg,
// cmig_cell_seq and cmig_index_calc.
`timescale 1ns / 1ps
`default_nettype none

// The generator walks a capsule mesh one grid cell per input item: the top
// hemisphere, the bottom hemisphere with reversed winding, then the
// cylinder band, and starts over after the last cell (flagged on m_tlast).
// It takes one item per cycle while s_tready is high; each item passes the
// cell register (counter stage) and the output register (index stage), where
// a slice by segment count product and an add set the critical path. A
// legal segment count write (3 to 64) rewinds the walk; other values are
// dropped. Write the configuration only while no item is in flight.
module capsule_mesh_index_generator (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration write port
    input  wire logic                       cfg_wen,
    input  wire logic                       cfg_addr,
    input  wire logic [cmig_pkg::SEG_W-1:0] cfg_wdata,
    // input items
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [0] restart, [7:1] zero
    // result items
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [13:0] index_a, [27:14] index_b, [41:28] index_c, [55:42] index_d,
    // [69:56] index_e, [83:70] index_f, [86:84] valid_count, [87] zero
    output logic [87:0]                     m_tdata,
    output logic [1:0]                      m_tuser,   // [1:0] part_of_mesh
    output logic                            m_tlast    // last_cell
);

    logic                cell_valid;
    logic                cell_ready;
    cmig_pkg::cell_t     seq_cell;
    cmig_pkg::cell_idx_t res;

    logic                out_vld_reg, out_vld_next;
    cmig_pkg::cell_idx_t out_reg;

    cmig_cell_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .restart    (s_tdata[0]),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_out   (seq_cell)
    );

    cmig_index_calc u_calc (
        .cell_in (seq_cell),
        .res     (res)
    );

    // Output register
    assign cell_ready = !out_vld_reg || m_tready;

    always_comb begin
        out_vld_next = out_vld_reg;
        if (m_tready) begin
            out_vld_next = 1'b0;
        end
        if (cell_valid && cell_ready) begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cell_valid && cell_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_reg.valid_count, out_reg.idx};
    assign m_tuser  = out_reg.part;
    assign m_tlast  = out_reg.last;

    // The last cell of the mesh is always a cylinder cell
    a_last_in_cyl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == cmig_pkg::PART_CYL))
        else $error("last cell outside the cylinder band");

    // Four indices only for cylinder cells, with the unused slots zero
    a_rim_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_reg.valid_count == cmig_pkg::VCNT_RIM)) |->
        ((m_tuser == cmig_pkg::PART_CYL) && (m_tdata[83:56] == '0)))
        else $error("short cell outside the cylinder band");

    // A waiting result item stays put until it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result item changed while waiting");

endmodule

`default_nettype wire
